/* design/eiu_pkg.sv */
// ----------------------------------------------------------------------------
// eiu_pkg: shared types and constants of the exponential integrator update
// Fixed-point widths, the ln2 constant, register codes and the record that
// travels down the update pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package eiu_pkg;

  localparam int DATA_W = 32;
  localparam int H_FRAC = 24;
  localparam int TAYLOR_TERMS = 20;

  // ln2 in Q.56
  localparam logic [55:0] LN2_Q56 = 56'hB17217F7D1CF7A;
  // exponent limit 44.0 with 40 fraction bits (Q16.16 times Q8.24)
  localparam logic [63:0] X_LIMIT = 64'd44 << 40;
  // any term at or above 2^40 LSB clips, whatever the state value
  localparam logic [40:0] TERM_BIG = 41'd1 << 40;

  typedef enum logic [0:0] {
    REG_STEP_SIZE = 1'b0,
    REG_THRESHOLD = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] y;
    logic [31:0]  amag;
    logic [31:0]  bmag;
    logic         aneg;
    logic         bneg;
    logic         use_exp;
    logic         hi_exp;
    logic         lo_exp;
    logic [63:0]  eul_prod;
    logic [63:0]  x_prod;
    logic [40:0]  eul_mag;
    logic [61:0]  krem;
    logic [5:0]   kq;
    logic signed [6:0] k;
    logic [55:0]  r;
    logic [56:0]  t;
    logic [57:0]  m;
    logic [63:0]  pp0;
    logic [63:0]  pp1;
    logic [63:0]  pp2;
    logic [63:0]  pp3;
    logic [119:0] e;
    logic         eneg;
    logic         big;
    logic [32:0]  drem;
    logic [89:0]  q;
    logic [121:0] aq;
    logic [62:0]  ax;
    logic [31:0]  extra;
    logic [40:0]  mag;
    logic         neg;
    logic [31:0]  res;
    logic         sat;
  } item_t;

endpackage

`default_nettype wire

/* design/exponential_integrator_update.sv */
// ----------------------------------------------------------------------------
// exponential_integrator_update: Rush-Larsen step of one ODE state element
// y + a/b*(exp(b*h)-1) for |b| above the threshold, else y + a*h, saturated.
// ----------------------------------------------------------------------------
//
//  channel | signals                                         | beat
//  --------+-------------------------------------------------+-------------------
//  in      | in_valid, in_ready, state_value, rate_term,     | valid & ready
//          | linear_coeff                                    |
//  out     | out_valid, out_ready, new_state_value, saturated| valid & ready
//  cfg     | cfg_we, cfg_index, cfg_data                     | cfg_we
//
// One beat per cycle in and out, unless a held result stalls the pipeline.
// The pipeline depth is set by the 20-term exp series (four stages per term: two
// split 32x32 multiplies, each summed) and the two bit-pair long dividers.
// The whole pipeline holds while a result waits at the output register.
// Reset clears the stage valid bits and loads the register reset values.
`default_nettype none

module exponential_integrator_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] state_value,
  input  logic signed [31:0] rate_term,
  input  logic signed [31:0] linear_coeff,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_state_value,
  output logic               saturated,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int K_STAGES  = 3;
  localparam int D1_STAGES = 45;
  localparam int D2_STAGES = 16;
  localparam int ST_IN  = 0;
  localparam int ST_MUL = ST_IN + 1;
  localparam int ST_RED = ST_MUL + 1;
  localparam int ST_KD  = ST_RED + 1;
  localparam int ST_KR  = ST_KD + K_STAGES;
  localparam int ST_TY  = ST_KR + 1;
  localparam int ST_E   = ST_TY + 4 * eiu_pkg::TAYLOR_TERMS;
  localparam int ST_EB  = ST_E + 1;
  localparam int ST_D1  = ST_EB + 1;
  localparam int ST_AQ  = ST_D1 + D1_STAGES;
  localparam int ST_AQS = ST_AQ + 1;
  localparam int ST_D2  = ST_AQS + 1;
  localparam int ST_MAG = ST_D2 + D2_STAGES;
  localparam int ST_OUT = ST_MAG + 1;
  localparam int NST    = ST_OUT + 1;

  localparam logic signed [42:0] SUM_MAX = 43'sd2147483647;
  localparam logic signed [42:0] SUM_MIN = -43'sd2147483648;

  logic [31:0] step_size;
  logic [30:0] small_coeff_threshold;

  logic [NST-1:0] vld;
  logic           en;
  eiu_pkg::item_t pipe_q [NST];
  wire eiu_pkg::item_t pipe_d [NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size             <= 32'd16777;
      small_coeff_threshold <= 31'd1;
    end else if (cfg_we) begin
      case (eiu_pkg::reg_idx_t'(cfg_index))
        eiu_pkg::REG_STEP_SIZE: step_size             <= cfg_data;
        eiu_pkg::REG_THRESHOLD: small_coeff_threshold <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // advance every stage together unless the result register is held
  assign en       = !vld[NST-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) pipe_q[i] <= pipe_d[i];
    end
  end

  // input capture: magnitudes and signs
  begin : g_in
    eiu_pkg::item_t d;
    always_comb begin
      d      = '0;
      d.y    = state_value;
      d.aneg = rate_term[31];
      d.bneg = linear_coeff[31];
      d.amag = rate_term[31] ? (~$unsigned(rate_term) + 32'd1) : $unsigned(rate_term);
      d.bmag = linear_coeff[31] ? (~$unsigned(linear_coeff) + 32'd1)
                                : $unsigned(linear_coeff);
    end
    assign pipe_d[ST_IN] = d;
  end

  begin : g_mul
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_MUL-1];
    always_comb begin
      d          = c;
      d.eul_prod = {32'd0, c.amag} * {32'd0, step_size};
      d.x_prod   = {32'd0, c.bmag} * {32'd0, step_size};
      d.use_exp  = {1'b0, c.bmag} > {2'b0, small_coeff_threshold};
    end
    assign pipe_d[ST_MUL] = d;
  end

  begin : g_red
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_RED-1];
    always_comb begin
      d         = c;
      d.eul_mag = 41'((c.eul_prod + 64'h80_0000) >> eiu_pkg::H_FRAC);
      d.hi_exp  = !c.bneg && (c.x_prod >= eiu_pkg::X_LIMIT);
      d.lo_exp  = c.bneg && (c.x_prod >= eiu_pkg::X_LIMIT);
      d.krem    = {c.x_prod[45:0], 16'd0};
      d.kq      = '0;
    end
    assign pipe_d[ST_RED] = d;
  end

  // k = floor(|x| / ln2), two quotient bits a stage
  for (genvar i = 0; i < K_STAGES; i++) begin : g_kdiv
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_KD+i-1];
    always_comb begin
      int b;
      logic [63:0] lsh;
      d = c;
      for (int j = 0; j < 2; j++) begin
        b   = 5 - 2 * i - j;
        lsh = {8'd0, eiu_pkg::LN2_Q56} << b;
        if ({2'b0, d.krem} >= lsh) begin
          d.krem  = 62'({2'b0, d.krem} - lsh);
          d.kq[b] = 1'b1;
        end
      end
    end
    assign pipe_d[ST_KD+i] = d;
  end

  // floor division for a negative exponent, then seed the series
  begin : g_kr
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_KR-1];
    always_comb begin
      d = c;
      if (!c.bneg) begin
        d.k = $signed({1'b0, c.kq});
        d.r = c.krem[55:0];
      end else if (c.krem == '0) begin
        d.k = -$signed({1'b0, c.kq});
        d.r = '0;
      end else begin
        d.k = $signed(~{1'b0, c.kq});
        d.r = eiu_pkg::LN2_Q56 - c.krem[55:0];
      end
      d.t = 57'd1 << 56;
      d.m = 58'd1 << 56;
    end
    assign pipe_d[ST_KR] = d;
  end

  // e^r as 20 series terms: t = floor(floor(t*r/2^56)/n)
  for (genvar n = 1; n <= eiu_pkg::TAYLOR_TERMS; n++) begin : g_tay
    localparam int BASE = ST_TY + 4 * (n - 1);
    localparam logic [62:0] RECIP = 63'(((64'd1 << 62) + 64'(n) - 64'd1) / 64'(n));
    eiu_pkg::item_t ca, da, cb, db, cc, dc, cd, dd;
    assign ca = pipe_q[BASE-1];
    assign cb = pipe_q[BASE];
    assign cc = pipe_q[BASE+1];
    assign cd = pipe_q[BASE+2];
    always_comb begin
      da     = ca;
      da.pp0 = {32'd0, ca.t[31:0]} * {32'd0, ca.r[31:0]};
      da.pp1 = {32'd0, ca.t[31:0]} * {40'd0, ca.r[55:32]};
      da.pp2 = {39'd0, ca.t[56:32]} * {32'd0, ca.r[31:0]};
      da.pp3 = {39'd0, ca.t[56:32]} * {40'd0, ca.r[55:32]};
    end
    always_comb begin
      logic [127:0] full;
      db   = cb;
      full = {64'd0, cb.pp0} + ({64'd0, cb.pp1} << 32) + ({64'd0, cb.pp2} << 32)
           + ({64'd0, cb.pp3} << 64);
      db.t = full[112:56];
    end
    always_comb begin
      dc     = cc;
      dc.pp0 = {32'd0, cc.t[31:0]} * {32'd0, RECIP[31:0]};
      dc.pp1 = {32'd0, cc.t[31:0]} * {33'd0, RECIP[62:32]};
      dc.pp2 = {39'd0, cc.t[56:32]} * {32'd0, RECIP[31:0]};
      dc.pp3 = {39'd0, cc.t[56:32]} * {33'd0, RECIP[62:32]};
    end
    always_comb begin
      logic [127:0] full;
      dd   = cd;
      full = {64'd0, cd.pp0} + ({64'd0, cd.pp1} << 32) + ({64'd0, cd.pp2} << 32)
           + ({64'd0, cd.pp3} << 64);
      dd.t = full[118:62];
      dd.m = cd.m + {1'b0, full[118:62]};
    end
    assign pipe_d[BASE]   = da;
    assign pipe_d[BASE+1] = db;
    assign pipe_d[BASE+2] = dc;
    assign pipe_d[BASE+3] = dd;
  end

  // E = e^x - 1 in Q.56, scaled by 2^k
  begin : g_e
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_E-1];
    always_comb begin
      logic [121:0] sh;
      logic [6:0]   s;
      logic [57:0]  mm;
      d  = c;
      sh = {64'd0, c.m} << c.k[5:0];
      s  = 7'(-c.k);
      mm = s[6] ? '0 : (c.m >> s[5:0]);
      if (c.lo_exp) begin
        d.e    = 120'd1 << 56;
        d.eneg = 1'b1;
      end else if (!c.k[6]) begin
        d.e    = 120'(sh - (122'd1 << 56));
        d.eneg = 1'b0;
      end else begin
        d.e    = (120'd1 << 56) - {62'd0, mm};
        d.eneg = 1'b1;
      end
      d.neg = c.aneg ^ d.eneg ^ c.bneg;
    end
    assign pipe_d[ST_E] = d;
  end

  // a quotient of 2^90 or more clips unless a is zero; otherwise seed the divider
  begin : g_eb
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_EB-1];
    always_comb begin
      d      = c;
      d.big  = {3'd0, c.e[119:90]} >= {1'b0, c.bmag};
      d.drem = {3'd0, c.e[119:90]};
      d.q    = '0;
    end
    assign pipe_d[ST_EB] = d;
  end

  for (genvar i = 0; i < D1_STAGES; i++) begin : g_d1
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_D1+i-1];
    always_comb begin
      int b;
      logic [32:0] rr;
      d  = c;
      rr = c.drem;
      for (int j = 0; j < 2; j++) begin
        b  = 89 - 2 * i - j;
        rr = {rr[31:0], d.e[b]};
        if (rr >= {1'b0, d.bmag}) begin
          rr     = rr - {1'b0, d.bmag};
          d.q[b] = 1'b1;
        end
      end
      d.drem = rr;
    end
    assign pipe_d[ST_D1+i] = d;
  end

  begin : g_aq
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_AQ-1];
    always_comb begin
      d     = c;
      d.pp0 = {32'd0, c.amag} * {32'd0, c.q[31:0]};
      d.pp1 = {32'd0, c.amag} * {32'd0, c.q[63:32]};
      d.pp2 = {32'd0, c.amag} * {38'd0, c.q[89:64]};
      d.pp3 = {32'd0, c.amag} * {32'd0, c.drem[31:0]};
    end
    assign pipe_d[ST_AQ] = d;
  end

  begin : g_aqs
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_AQS-1];
    always_comb begin
      d       = c;
      d.aq    = {58'd0, c.pp0} + ({58'd0, c.pp1} << 32) + ({58'd0, c.pp2} << 64);
      d.ax    = c.pp3[62:0];
      d.drem  = {2'd0, c.pp3[62:32]};
      d.extra = '0;
    end
    assign pipe_d[ST_AQS] = d;
  end

  // floor(|a|*R / |b|), below |a| so 32 quotient bits
  for (genvar i = 0; i < D2_STAGES; i++) begin : g_d2
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_D2+i-1];
    always_comb begin
      int b;
      logic [32:0] rr;
      d  = c;
      rr = c.drem;
      for (int j = 0; j < 2; j++) begin
        b  = 31 - 2 * i - j;
        rr = {rr[31:0], d.ax[b]};
        if (rr >= {1'b0, d.bmag}) begin
          rr         = rr - {1'b0, d.bmag};
          d.extra[b] = 1'b1;
        end
      end
      d.drem = rr;
    end
    assign pipe_d[ST_D2+i] = d;
  end

  begin : g_mag
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_MAG-1];
    always_comb begin
      logic [122:0] ts;
      logic [40:0]  em;
      d  = c;
      ts = {1'b0, c.aq} + {91'd0, c.extra};
      if (c.hi_exp) begin
        em = (c.amag == '0) ? '0 : eiu_pkg::TERM_BIG;
      end else if (c.amag == '0) begin
        em = '0;
      end else if (c.big || ts >= (123'd1 << 90)) begin
        em = eiu_pkg::TERM_BIG;
      end else begin
        em = 41'((ts + (123'd1 << 55)) >> 56);
      end
      d.mag = c.use_exp ? em : c.eul_mag;
      d.neg = (c.use_exp && !c.hi_exp) ? c.neg : c.aneg;
    end
    assign pipe_d[ST_MAG] = d;
  end

  begin : g_out
    eiu_pkg::item_t c, d;
    assign c = pipe_q[ST_OUT-1];
    always_comb begin
      logic signed [42:0] sm;
      d  = c;
      sm = c.neg ? (43'(c.y) - $signed({2'b0, c.mag}))
                 : (43'(c.y) + $signed({2'b0, c.mag}));
      d.sat = 1'b0;
      if (sm > SUM_MAX) begin
        sm    = SUM_MAX;
        d.sat = 1'b1;
      end else if (sm < SUM_MIN) begin
        sm    = SUM_MIN;
        d.sat = 1'b1;
      end
      d.res = sm[31:0];
    end
    assign pipe_d[ST_OUT] = d;
  end

  assign out_valid       = vld[NST-1];
  assign new_state_value = $signed(pipe_q[NST-1].res);
  assign saturated       = pipe_q[NST-1].sat;

endmodule

`default_nettype wire

/* design/eiu_chk.sv */
// ----------------------------------------------------------------------------
// eiu_chk: port-level checks for the exponential integrator update
// Watches the handshakes and the saturation flag; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module eiu_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] new_state_value,
  input logic               saturated
);

  localparam logic signed [31:0] V_MAX = $signed({1'b0, {(eiu_pkg::DATA_W-1){1'b1}}});
  localparam logic signed [31:0] V_MIN = $signed({1'b1, {(eiu_pkg::DATA_W-1){1'b0}}});

  // no result may appear straight out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // input is back-pressured only by a held result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output free");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (new_state_value == V_MAX || new_state_value == V_MIN))
    else $error("saturated result not at a rail");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(new_state_value) && $stable(saturated)))
    else $error("held result beat changed");

endmodule

bind exponential_integrator_update eiu_chk u_eiu_chk (.*);

`default_nettype wire

/* bench/exponential_integrator_update_tb.sv */
// ----------------------------------------------------------------------------
// exponential_integrator_update_tb: self-checking bench of the Rush-Larsen step
// Drives state elements through the valid/ready input, predicts each updated
// value in fixed point (Euler form, exp series with divide, saturation) and
// compares every output beat in order, under several step and threshold
// settings and several patterns of input gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

class update_scoreboard;
  localparam longint LN2 = 64'h00B17217F7D1CF7A;
  localparam logic [63:0] EXP_LIM = 64'd44 << 40;
  localparam logic [63:0] BIG_TERM = 64'd1 << 40;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } update_t;

  update_t     expected_updates[$];
  logic [31:0] step_h;
  logic [30:0] euler_thr;
  int          errors;
  int          checked;
  int          sat_seen;

  function new();
    step_h = 32'd16777;
    euler_thr = 31'd1;
    errors = 0;
    checked = 0;
    sat_seen = 0;
  endfunction

  function void set_reg(eiu_pkg::reg_idx_t idx, logic [31:0] v);
    if (idx == eiu_pkg::REG_STEP_SIZE) step_h = v;
    else euler_thr = v[30:0];
  endfunction

  // e^r for r in [0, ln2), Q.56, by a truncated 21-term series
  function logic [63:0] exp_series(logic [63:0] r);
    logic [63:0]  acc;
    logic [63:0]  t;
    logic [127:0] p;
    acc = 64'd1 << 56;
    t = 64'd1 << 56;
    for (int n = 1; n <= 20; n++) begin
      p = {64'd0, t} * {64'd0, r};
      t = p[119:56] / n;
      acc += t;
    end
    return acc;
  endfunction

  function update_t rush_larsen(logic signed [31:0] y, logic signed [31:0] a,
                                logic signed [31:0] b);
    logic [31:0]  amag, bmag;
    logic         aneg, bneg, eneg, neg;
    logic [63:0]  xmag, mag, m, rem, extra;
    logic [127:0] e, q, tt;
    longint       x56, k, r, sum;
    update_t      u;
    aneg = a[31];
    bneg = b[31];
    amag = aneg ? ~a + 32'd1 : a;
    bmag = bneg ? ~b + 32'd1 : b;
    eneg = 1'b0;
    if ({1'b0, bmag} > {2'b0, euler_thr}) begin
      xmag = {32'd0, bmag} * {32'd0, step_h};
      if (!bneg && xmag >= EXP_LIM) begin
        neg = aneg;
        mag = (amag == 0) ? 64'd0 : BIG_TERM;
      end else begin
        if (bneg && xmag >= EXP_LIM) begin
          // exp underflows to zero
          e = 128'd1 << 56;
          eneg = 1'b1;
        end else begin
          x56 = longint'(xmag << 16);
          if (bneg) x56 = -x56;
          k = x56 / LN2;
          r = x56 - k * LN2;
          if (r < 0) begin
            r += LN2;
            k--;
          end
          m = exp_series(r);
          if (k >= 0) begin
            e = ({64'd0, m} << k) - (128'd1 << 56);
          end else begin
            e = (128'd1 << 56) - ((-k) >= 64 ? 128'd0 : {64'd0, m >> (-k)});
            eneg = 1'b1;
          end
        end
        neg = aneg ^ eneg ^ bneg;
        q = e / bmag;
        rem = e % bmag;
        if (amag == 0) begin
          mag = 64'd0;
        end else if (q[127:64] >= (64'd1 << 26)) begin
          mag = BIG_TERM;
        end else begin
          extra = ({32'd0, amag} * rem) / bmag;
          tt = q * amag + extra + (128'd1 << 55);
          if (tt[127:64] >= (64'd1 << 32)) mag = BIG_TERM;
          else begin
            mag = tt[119:56];
            if (mag > BIG_TERM) mag = BIG_TERM;
          end
        end
      end
    end else begin
      mag = ({32'd0, amag} * {32'd0, step_h} + (64'd1 << 23)) >> 24;
      neg = aneg;
    end
    sum = neg ? longint'(y) - longint'(mag) : longint'(y) + longint'(mag);
    u.sat = 1'b0;
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
      u.sat = 1'b1;
    end
    if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
      u.sat = 1'b1;
    end
    u.value = sum[31:0];
    return u;
  endfunction

  function void note_input(logic signed [31:0] y, logic signed [31:0] a,
                           logic signed [31:0] b);
    expected_updates.push_back(rush_larsen(y, a, b));
  endfunction

  function void check_result(logic [31:0] value, logic sat);
    update_t w;
    if (expected_updates.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat: value %h sat %b", value, sat);
      return;
    end
    w = expected_updates.pop_front();
    checked++;
    if (sat) sat_seen++;
    if (value !== w.value || sat !== w.sat) begin
      errors++;
      if (errors <= 10)
        $display("mismatch on result %0d: expected %h sat %b, got %h sat %b",
                 checked, w.value, w.sat, value, sat);
    end
  endfunction

  function int pending();
    return expected_updates.size();
  endfunction
endclass

module exponential_integrator_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] state_value = '0;
  logic signed [31:0] rate_term = '0;
  logic signed [31:0] linear_coeff = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] new_state_value;
  logic               saturated;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  update_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_go = 1'b0;
  int  hold_cnt = 0;
  int  quiet_cycles = 0;
  int  sent = 0;

  exponential_integrator_update dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, or one long hold-off on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(new_state_value, saturated);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(logic [31:0] y, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    state_value <= y;
    rate_term <= a;
    linear_coeff <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(y, a, b);
    sent++;
  endtask

  // hold the sender until every result is back, then let the pipe empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic write_reg(eiu_pkg::reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coeff();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 1 << 20);
      2: v = $urandom_range(0, 1 << 24);
      3: v = $urandom_range(0, 3);
      default: v = $urandom_range(0, 1 << 16);
    endcase
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'h0;
      default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    endcase
  endfunction

  initial begin
    logic [31:0] h_set[6];
    logic [31:0] thr_set[6];
    h_set = '{32'hFFFF_FFFF, 32'h0, 32'd16777, $urandom, 32'h0100_0000,
              $urandom_range(0, 1 << 22)};
    thr_set = '{32'h0, 32'h7FFF_FFFF, 32'd1, $urandom_range(0, 1 << 18),
                32'h0001_0000, 32'h0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: Euler edges, threshold edge, exp path
    send_item(32'h0, 32'h0, 32'h0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h1);
    send_item(32'h0, 32'h7FFF_FFFF, 32'h2);
    send_item(32'h0005_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_item(32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(32'h1234_5678, 32'h0, 32'h0010_0000);
    drain();

    // longest step, no threshold: huge exponents both ways, huge quotients
    write_reg(eiu_pkg::REG_STEP_SIZE, h_set[0]);
    write_reg(eiu_pkg::REG_THRESHOLD, thr_set[0]);
    send_item(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(32'h0100_0000, 32'h0, 32'h7FFF_FFFF);
    send_item(32'h0, 32'h0001_0000, 32'h8000_0000);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_item(32'h0, 32'h7FFF_FFFF, 32'h0000_0001);
    send_item(32'h0, 32'h0001_0000, 32'h0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'h0, 32'h0001_0000, 32'h0002_C000);
    send_item(32'h0, 32'hFFFF_0000, 32'hFFFD_4000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(eiu_pkg::REG_STEP_SIZE, h_set[ph]);
      write_reg(eiu_pkg::REG_THRESHOLD, thr_set[(ph + 1) % 6]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int i = 0; i < 240; i++) begin
        if (ph == 4 && i == 20) hold_go = 1'b1;
        send_item($urandom, rand_rate(), rand_coeff());
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    $display("covered %0d updates, %0d saturated, over 8 step/threshold settings",
             sb.checked, sb.sat_seen);
    $display("input gaps and output stalls mixed, with one long output hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

`default_nettype wire
